// ===== hdl/dns_query_name_extractor_macros.svh =====
// Assertion macros shared by the DNS name extractor RTL
`ifndef DNS_QUERY_NAME_EXTRACTOR_MACROS_SVH
`define DNS_QUERY_NAME_EXTRACTOR_MACROS_SVH

// Clocked assertion, masked while reset is held
`define DNSQNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define DNSQNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/dnsqne_pkg.sv =====
// Shared types and constants for the DNS query name extractor
package dnsqne_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int NAME_BUFFER  = 256;

  localparam logic [7:0] DOT_CHAR     = 8'h2E;
  localparam logic [7:0] PTR_MASK     = 8'hC0;
  localparam logic [5:0] MAX_LABEL    = 6'd63;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // One result word from the parser
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] name_char;
    logic [7:0] name_length;
  } res_t;

endpackage

// ===== hdl/dnsqne_ifs.sv =====
// Valid/ready channel interfaces for packet bytes and name results
interface dnsqne_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_last;

  modport source (output valid, output data_byte, output packet_last, input ready);
  modport sink   (input valid, input data_byte, input packet_last, output ready);
endinterface

interface dnsqne_out_if;
  logic               valid;
  logic               ready;
  dnsqne_pkg::kind_t  result_kind;
  logic [7:0]         name_char;
  logic [7:0]         name_length;

  modport source (output valid, output result_kind, output name_char, output name_length,
                  input ready);
  modport sink   (input valid, input result_kind, input name_char, input name_length,
                  output ready);
endinterface

// ===== hdl/dns_query_name_extractor.sv =====
// Top level: DNS query name extractor with input and result registers
//
//   channel | dir | words
//   in_chan | in  | data_byte[7:0], packet_last
//   out_chan| out | result_kind[1:0], name_char[7:0], name_length[7:0]
//
// One packet byte per cycle sustained while the output is not stalled; a byte taken
// into the input register has its result registered in the output register once the output is free.
// The input register keeps taking a byte while a result waits on a stalled
// output, so one byte is absorbed before in_chan.ready drops.
// Bytes that give no result pass through without occupying the output.
// Synchronous active-low reset returns the parser to the header phase.
`include "dns_query_name_extractor_macros.svh"

module dns_query_name_extractor (
  input  logic                clk,
  input  logic                rst_n,
  dnsqne_in_if.sink           in_chan,
  dnsqne_out_if.source        out_chan
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic              out_valid_r;
  dnsqne_pkg::kind_t out_kind_r;
  logic [7:0]        out_char_r;
  logic [7:0]        out_len_r;

  logic              adv;
  logic              in_ready;
  dnsqne_pkg::res_t  res;

  assign adv      = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || adv;

  dnsqne_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .data_byte   (in_byte_r),
    .packet_last (in_last_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_byte_r <= in_chan.data_byte;
      in_last_r <= in_chan.packet_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_kind_r <= res.kind;
      out_char_r <= res.name_char;
      out_len_r  <= res.name_length;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.name_char   = out_char_r;
  assign out_chan.name_length = out_len_r;

  `DNSQNE_ASSERT(a_stall_blocks, (in_valid_r && out_valid_r && !out_chan.ready) |-> !in_ready, "input taken while both stages full")
  `DNSQNE_ASSERT(a_drain, (in_valid_r && !out_valid_r && !in_chan.valid) |=> !in_valid_r, "held byte not consumed with output free")
  `DNSQNE_ASSERT(a_char_nolen, (out_valid_r && out_kind_r == dnsqne_pkg::KIND_CHAR) |-> (out_len_r == 8'd0), "character word carries a length")
  `DNSQNE_ASSERT(a_status_nochar, (out_valid_r && out_kind_r != dnsqne_pkg::KIND_CHAR) |-> (out_char_r == 8'd0), "status word carries a character")

endmodule

// ===== hdl/dnsqne_parser.sv =====
// Label parser: header skip, length/label decode and status generation
`include "dns_query_name_extractor_macros.svh"

module dnsqne_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              packet_last,
  output dnsqne_pkg::res_t  res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_LABEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [5:0]  lbl_rem_r, lbl_rem_nxt;
  logic [7:0]  chars_r, chars_nxt;

  logic [4:0]  hdr_inc;
  logic [9:0]  base;
  logic [9:0]  sum;
  logic [5:0]  rem_dec;
  logic        status;
  logic        bad;
  logic        have_chr;
  logic [7:0]  chr;
  logic        go_reset;

  always_comb begin
    hdr_inc  = {1'b0, hdr_cnt_r} + 5'd1;
    base     = {2'b00, chars_r} + {9'd0, (chars_r != 8'd0)};
    sum      = base + {2'b00, data_byte};
    rem_dec  = lbl_rem_r - 6'd1;

    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    lbl_rem_nxt = lbl_rem_r;
    chars_nxt   = chars_r;
    status      = 1'b0;
    bad         = 1'b0;
    have_chr    = 1'b0;
    chr         = 8'd0;
    go_reset    = 1'b0;
    res         = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_inc >= 5'(dnsqne_pkg::HEADER_BYTES)) begin
          hdr_cnt_nxt = 4'd0;
          phase_nxt   = PH_LENGTH;
        end else begin
          hdr_cnt_nxt = hdr_inc[3:0];
        end
      end
      PH_LENGTH: begin
        if (data_byte == 8'd0) begin
          status = 1'b1;
          bad    = (chars_r == 8'd0) ||
                   ({2'b00, chars_r} >= 10'(dnsqne_pkg::NAME_BUFFER));
        end else if ((data_byte & dnsqne_pkg::PTR_MASK) != 8'd0 ||
                     data_byte > {2'b00, dnsqne_pkg::MAX_LABEL}) begin
          // compression pointer or oversized label
          status = 1'b1;
          bad    = 1'b1;
        end else if (sum >= 10'(dnsqne_pkg::NAME_BUFFER)) begin
          status = 1'b1;
          bad    = 1'b1;
        end else begin
          if (chars_r != 8'd0) begin
            have_chr = 1'b1;
            chr      = dnsqne_pkg::DOT_CHAR;
          end
          chars_nxt   = sum[7:0];
          lbl_rem_nxt = data_byte[5:0];
          phase_nxt   = PH_LABEL;
        end
      end
      PH_LABEL: begin
        have_chr    = 1'b1;
        chr         = data_byte;
        lbl_rem_nxt = rem_dec;
        if (rem_dec == 6'd0) phase_nxt = PH_LENGTH;
      end
      PH_DONE: begin
        go_reset = packet_last;
      end
      default: ;
    endcase

    if (phase_r != PH_DONE) begin
      // packet ended before the name finished
      if (!status && packet_last) begin
        status = 1'b1;
        bad    = 1'b1;
      end
      if (status) begin
        res.valid       = 1'b1;
        res.kind        = bad ? dnsqne_pkg::KIND_BAD : dnsqne_pkg::KIND_OK;
        res.name_length = bad ? 8'd0 : chars_r;
        if (packet_last) go_reset = 1'b1;
        else             phase_nxt = PH_DONE;
      end else if (have_chr) begin
        res.valid     = 1'b1;
        res.kind      = dnsqne_pkg::KIND_CHAR;
        res.name_char = chr;
      end
    end

    if (go_reset) begin
      phase_nxt   = PH_HEADER;
      hdr_cnt_nxt = 4'd0;
      lbl_rem_nxt = 6'd0;
      chars_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 4'd0;
      lbl_rem_r <= 6'd0;
      chars_r   <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      lbl_rem_r <= lbl_rem_nxt;
      chars_r   <= chars_nxt;
    end
  end

  `DNSQNE_ASSERT(a_label_nonzero, (phase_r == PH_LABEL) |-> (lbl_rem_r != 6'd0), "label phase with no bytes left")
  `DNSQNE_ASSERT(a_hdr_bound, {1'b0, hdr_cnt_r} < 5'(dnsqne_pkg::HEADER_BYTES), "header count out of range")
  `DNSQNE_ASSERT(a_ok_len, (res.valid && res.kind == dnsqne_pkg::KIND_OK) |-> (res.name_length != 8'd0), "ok status with empty name")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the DNS query name extractor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BYTES = 130;

  typedef enum logic [1:0] {P_HEADER, P_LENGTH, P_LABEL, P_DONE} phase_t;
  typedef enum int {
    SH_GOOD, SH_HEADER_CUT, SH_EMPTY, SH_BAD_LEN, SH_CUT_LENGTH, SH_CUT_LABEL, SH_NOISE
  } shape_t;

  typedef struct packed {
    dnsqne_pkg::kind_t kind;
    logic [7:0]        ch;
    logic [7:0]        len;
  } name_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dnsqne_in_if  in_ch ();
  dnsqne_out_if out_ch ();

  dns_query_name_extractor u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  phase_t dec_phase;
  int     dec_hdr_cnt;
  int     dec_left;
  int     dec_used;

  name_word_t name_results_due[$];
  logic [7:0] pkt_bytes[$];

  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;

  int n_errors        = 0;
  int n_packets       = 0;
  int n_bytes_sent    = 0;
  int n_words_checked = 0;
  int n_names_ok      = 0;
  int n_names_bad     = 0;
  int idle_cycles     = 0;

  function automatic void clear_decoder();
    dec_phase   = P_HEADER;
    dec_hdr_cnt = 0;
    dec_left    = 0;
    dec_used    = 0;
  endfunction

  // Advances the shadow decoder by one byte and queues the word it yields.
  function automatic void decode_byte(logic [7:0] b, logic last);
    logic       status;
    logic       bad;
    logic       give_char;
    logic [7:0] ch;
    int         base;
    status    = 1'b0;
    bad       = 1'b0;
    give_char = 1'b0;
    ch        = 8'h00;
    if (dec_phase == P_DONE) begin
      if (last) clear_decoder();
    end else begin
      case (dec_phase)
        P_HEADER: begin
          if (dec_hdr_cnt + 1 >= dnsqne_pkg::HEADER_BYTES) begin
            dec_hdr_cnt = 0;
            dec_phase   = P_LENGTH;
          end else begin
            dec_hdr_cnt++;
          end
        end
        P_LENGTH: begin
          base = dec_used + ((dec_used != 0) ? 1 : 0);
          if (b == 8'h00) begin
            status = 1'b1;
            bad    = (dec_used == 0);
          end else if ((b & dnsqne_pkg::PTR_MASK) != 8'h00 || b > dnsqne_pkg::MAX_LABEL) begin
            status = 1'b1;
            bad    = 1'b1;
          end else if (base + int'(b) >= dnsqne_pkg::NAME_BUFFER) begin
            // label would fill the name buffer; no dot for it
            status = 1'b1;
            bad    = 1'b1;
          end else begin
            give_char = (dec_used != 0);
            ch        = dnsqne_pkg::DOT_CHAR;
            dec_used  = base + int'(b);
            dec_left  = int'(b);
            dec_phase = P_LABEL;
          end
        end
        default: begin
          give_char = 1'b1;
          ch        = b;
          dec_left--;
          if (dec_left == 0) dec_phase = P_LENGTH;
        end
      endcase
      if (last && !status) begin
        status = 1'b1;
        bad    = 1'b1;
      end
      if (status) begin
        name_results_due.push_back('{bad ? dnsqne_pkg::KIND_BAD : dnsqne_pkg::KIND_OK, 8'h00,
                                     bad ? 8'h00 : 8'(dec_used)});
        if (last) clear_decoder();
        else dec_phase = P_DONE;
      end else if (give_char) begin
        name_results_due.push_back('{dnsqne_pkg::KIND_CHAR, ch, 8'h00});
      end
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_label(int len);
    pkt_bytes.push_back(8'(len));
    repeat (len) pkt_bytes.push_back(rand_byte());
  endfunction

  function automatic void add_labels(int n);
    repeat (n) add_label($urandom_range(1, ($urandom_range(0, 9) == 0) ? 63 : 8));
  endfunction

  function automatic void add_trailer();
    repeat ($urandom_range(0, 3)) pkt_bytes.push_back(rand_byte());
  endfunction

  function automatic void add_header();
    repeat (dnsqne_pkg::HEADER_BYTES) pkt_bytes.push_back(rand_byte());
  endfunction

  function automatic void build_packet(shape_t shape);
    int len;
    pkt_bytes.delete();
    case (shape)
      SH_NOISE: begin
        repeat ($urandom_range(1, 40)) pkt_bytes.push_back(rand_byte());
      end
      SH_HEADER_CUT: begin
        repeat ($urandom_range(1, dnsqne_pkg::HEADER_BYTES)) pkt_bytes.push_back(rand_byte());
      end
      SH_EMPTY: begin
        add_header();
        pkt_bytes.push_back(8'h00);
        add_trailer();
      end
      SH_BAD_LEN: begin
        // compression pointer or over-long label
        add_header();
        add_labels($urandom_range(0, 2));
        pkt_bytes.push_back(8'($urandom_range(64, 255)));
        add_trailer();
      end
      SH_CUT_LENGTH: begin
        add_header();
        add_labels($urandom_range(0, 2));
        pkt_bytes.push_back(8'($urandom_range(1, 63)));
      end
      SH_CUT_LABEL: begin
        add_header();
        add_labels($urandom_range(0, 2));
        len = $urandom_range(2, 20);
        pkt_bytes.push_back(8'(len));
        repeat ($urandom_range(1, len - 1)) pkt_bytes.push_back(rand_byte());
      end
      default: begin
        add_header();
        add_labels($urandom_range(1, 4));
        pkt_bytes.push_back(8'h00);
        add_trailer();
      end
    endcase
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (src_gaps && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.packet_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, last);
    n_bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    n_packets++;
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (name_results_due.size() != 0);
  endtask

  // Packet that ends two bytes into the header.
  task automatic test_header_cut();
    pkt_bytes = '{8'h00, 8'hFF};
    send_packet();
  endtask

  // Two one-char labels give "x." plus 0xFF; a byte after the status is ignored.
  task automatic test_dotted_name();
    pkt_bytes.delete();
    for (int i = 0; i < dnsqne_pkg::HEADER_BYTES; i++) begin
      pkt_bytes.push_back((i % 2 == 0) ? 8'h00 : 8'hFF);
    end
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(8'h78);
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    send_packet();
  endtask

  task automatic test_random_packets();
    int start;
    int done_bytes;
    start = n_bytes_sent;
    done_bytes = 0;
    while (done_bytes < RANDOM_BYTES) begin
      // a stretch with both sides streaming flat out
      src_gaps  = !(done_bytes >= 30 && done_bytes < 100);
      sink_gaps = src_gaps;
      if ($urandom_range(0, 99) < 55) build_packet(SH_GOOD);
      else build_packet(shape_t'($urandom_range(1, 6)));
      send_packet();
      if ($urandom_range(0, 9) == 0) wait_for_drain();
      done_bytes = n_bytes_sent - start;
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_pause_for_results();
    build_packet(SH_GOOD);
    send_packet();
    wait_for_drain();
  endtask

  task automatic test_name_buffer_limit();
    // four full labels make 255 chars, the most that fits; one more
    // one-char label would reach the buffer size
    pkt_bytes.delete();
    add_header();
    repeat (4) add_label(63);
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(rand_byte());
    send_packet();
  endtask

  always @(negedge clk) begin
    out_ch.ready <= sink_gaps ? ($urandom_range(0, 99) >= 32) : 1'b1;
  end

  always @(posedge clk) begin
    name_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_words_checked++;
      if (name_results_due.size() == 0) begin
        $error("unexpected result word: kind %0d char %02h length %0d",
               out_ch.result_kind, out_ch.name_char, out_ch.name_length);
        n_errors++;
      end else begin
        want = name_results_due.pop_front();
        if (want.kind == dnsqne_pkg::KIND_OK) n_names_ok++;
        if (want.kind == dnsqne_pkg::KIND_BAD) n_names_bad++;
        if (out_ch.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_ch.result_kind);
          n_errors++;
        end
        if (out_ch.name_char !== want.ch) begin
          $error("name_char: expected %02h, got %02h", want.ch, out_ch.name_char);
          n_errors++;
        end
        if (out_ch.name_length !== want.len) begin
          $error("name_length: expected %0d, got %0d", want.len, out_ch.name_length);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no progress for %0d cycles, %0d words still due", idle_cycles,
             name_results_due.size());
      $display("dns_query_name_extractor regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.packet_last = 1'b0;
    out_ch.ready      = 1'b0;
    clear_decoder();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_header_cut();
    test_dotted_name();
    test_random_packets();
    test_pause_for_results();
    test_name_buffer_limit();

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (name_results_due.size() != 0) begin
      $error("%0d expected words never arrived", name_results_due.size());
      n_errors++;
    end
    $display("sent %0d packets (%0d bytes), checked %0d words: %0d names ok, %0d malformed",
             n_packets, n_bytes_sent, n_words_checked, n_names_ok, n_names_bad);
    if (n_errors == 0) begin
      $display("dns_query_name_extractor regression: pass");
    end else begin
      $display("dns_query_name_extractor regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dnsqne_pkg.sv
hdl/dnsqne_ifs.sv
hdl/dnsqne_parser.sv
hdl/dns_query_name_extractor.sv
tb/testbench.sv
